FILE: hw/rtl/triangle_strip_unfolder_assert.svh
// Assertion macros used by the triangle strip unfolder checker.
`ifndef TRIANGLE_STRIP_UNFOLDER_ASSERT_SVH
`define TRIANGLE_STRIP_UNFOLDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsu check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsu check failed");

`endif

FILE: hw/rtl/tsu_pkg.sv
// Shared types, constants and tables of the triangle strip unfolder.
`timescale 1ns / 1ps
package tsu_pkg;

	localparam int COORD_W      = 32;
	localparam int IN_W         = 3 * COORD_W;
	localparam int OUT_W        = 2 * COORD_W;
	localparam int CORDIC_STEPS = 24;

	localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
	localparam logic signed [39:0] KINV_Q30     = 40'sd652032874;

	// arctangent of 2^-i as a binary angle
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef enum logic [1:0] {PH_ORIGIN, PH_AXIS, PH_TURN} phase_t;

	typedef enum logic [3:0] {
		CS_IDLE, CS_LNORM, CS_MUL, CS_SQRT, CS_ANORM, CS_VINIT,
		CS_CORDIC, CS_HEAD, CS_FIN, CS_DONE
	} core_state_t;

	typedef enum logic [1:0] {MK_LEN, MK_CROSS, MK_CSQ, MK_SCALE} mul_kind_t;

	typedef struct packed {
		phase_t             phase;
		logic               odd;
		logic [31:0]        heading;
		logic signed [31:0] last_x;
		logic signed [31:0] last_y;
		logic signed [32:0] ax;
		logic signed [32:0] ay;
		logic signed [32:0] az;
		logic signed [32:0] bx;
		logic signed [32:0] by;
		logic signed [32:0] bz;
	} job_t;

	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               deg;
		logic               sat;
		logic [31:0]        heading;
	} res_t;

endpackage

FILE: hw/rtl/tsu_core.sv
// Sequenced geometry core: shared multiplier, square root and CORDIC unit.
`timescale 1ns / 1ps
module tsu_core import tsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic take,
	input  job_t job,
	output logic busy,
	output logic res_valid,
	output res_t res
);

	localparam logic [3:0] N_LEN   = 4'd3;
	localparam logic [3:0] N_CROSS = 4'd9;
	localparam logic [3:0] N_CSQ   = 4'd3;
	localparam logic [3:0] N_SCALE = 4'd4;

	core_state_t state_q, state_d;
	mul_kind_t   kind_q, kind_nx;

	phase_t             ph_q;
	logic               odd_q, deg_q, ls_q, vec_q;
	logic [31:0]        head_q;
	logic signed [31:0] last_x_q, last_y_q;
	logic [31:0]        am_q [3];
	logic [31:0]        bm_q [3];
	logic               asg_q [3];
	logic               bsg_q [3];
	logic [3:0]         mk_cnt_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [33:0] dot_q;
	logic [63:0]        n_q, r_q;
	logic [4:0]         t_q, i_q;
	logic [32:0]        len_q;
	logic signed [39:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [35:0]        offx_q, offy_q;
	res_t               res_q;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [32:0] sat37(input logic signed [36:0] v);
		if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111))
			return {1'b0, v[31:0]};
		return {1'b1, v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF};
	endfunction

	// ---- flags and counts ----
	logic [3:0] mk_n;
	logic       mk_done, sqrt_done, cordic_done, lbig, abig, bbig;
	logic [3:0] jp;

	always_comb begin
		case (kind_q)
			MK_LEN:   mk_n = N_LEN;
			MK_CROSS: mk_n = N_CROSS;
			MK_CSQ:   mk_n = N_CSQ;
			default:  mk_n = N_SCALE;
		endcase
	end

	assign mk_done     = (mk_cnt_q == mk_n);
	assign jp          = mk_cnt_q - 4'd1;
	assign sqrt_done   = (t_q == 5'd31);
	assign cordic_done = (i_q == 5'(CORDIC_STEPS - 1));
	assign lbig = bm_q[0][31] | bm_q[1][31] | bm_q[2][31];
	assign abig = (|am_q[0][31:15]) | (|am_q[1][31:15]) | (|am_q[2][31:15]);
	assign bbig = (|bm_q[0][31:15]) | (|bm_q[1][31:15]) | (|bm_q[2][31:15]);

	// ---- multiplier operand select ----
	logic signed [15:0] na [3];
	logic signed [15:0] nb [3];
	logic signed [32:0] op_a, op_b;
	logic signed [39:0] cx_abs, sy_abs;
	logic [31:0]        cmx, cmy;
	logic signed [32:0] lo33, hi33;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			na[k] = asg_q[k] ? -$signed({1'b0, am_q[k][14:0]}) : $signed({1'b0, am_q[k][14:0]});
			nb[k] = bsg_q[k] ? -$signed({1'b0, bm_q[k][14:0]}) : $signed({1'b0, bm_q[k][14:0]});
		end
	end

	assign cx_abs = x_q[39] ? -x_q : x_q;
	assign sy_abs = y_q[39] ? -y_q : y_q;
	assign cmx    = cx_abs[31:0];
	assign cmy    = sy_abs[31:0];
	assign lo33   = $signed({13'd0, len_q[19:0]});
	assign hi33   = $signed({20'd0, len_q[32:20]});

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (kind_q)
			MK_LEN: begin
				case (mk_cnt_q)
					4'd0:    op_a = $signed({1'b0, bm_q[0]});
					4'd1:    op_a = $signed({1'b0, bm_q[1]});
					default: op_a = $signed({1'b0, bm_q[2]});
				endcase
				op_b = op_a;
			end
			MK_CROSS: begin
				case (mk_cnt_q)
					4'd0: begin op_a = 33'(na[1]); op_b = 33'(nb[2]); end
					4'd1: begin op_a = 33'(na[2]); op_b = 33'(nb[1]); end
					4'd2: begin op_a = 33'(na[2]); op_b = 33'(nb[0]); end
					4'd3: begin op_a = 33'(na[0]); op_b = 33'(nb[2]); end
					4'd4: begin op_a = 33'(na[0]); op_b = 33'(nb[1]); end
					4'd5: begin op_a = 33'(na[1]); op_b = 33'(nb[0]); end
					4'd6: begin op_a = 33'(na[0]); op_b = 33'(nb[0]); end
					4'd7: begin op_a = 33'(na[1]); op_b = 33'(nb[1]); end
					default: begin op_a = 33'(na[2]); op_b = 33'(nb[2]); end
				endcase
			end
			MK_CSQ: begin
				case (mk_cnt_q)
					4'd0:    op_a = 33'(cx_q);
					4'd1:    op_a = 33'(cy_q);
					default: op_a = 33'(cz_q);
				endcase
				op_b = op_a;
			end
			default: begin
				case (mk_cnt_q)
					4'd0:    begin op_a = lo33; op_b = $signed({1'b0, cmx}); end
					4'd1:    begin op_a = hi33; op_b = $signed({1'b0, cmx}); end
					4'd2:    begin op_a = lo33; op_b = $signed({1'b0, cmy}); end
					default: begin op_a = hi33; op_b = $signed({1'b0, cmy}); end
				endcase
			end
		endcase
	end

	logic signed [65:0] sum_w, dif_w;
	assign sum_w = acc_q + prod_q;
	assign dif_w = acc_q - prod_q;

	// ---- square root step, two bits per cycle ----
	logic [5:0]  sq_sh;
	logic [63:0] sq_bit, sq_trial, n_nx, r_nx;
	logic        sq_ge;

	assign sq_sh    = 6'd62 - {t_q, 1'b0};
	assign sq_bit   = 64'd1 << sq_sh;
	assign sq_trial = r_q + sq_bit;
	assign sq_ge    = (n_q >= sq_trial);
	assign n_nx     = sq_ge ? n_q - sq_trial : n_q;
	assign r_nx     = sq_ge ? (r_q >> 1) + sq_bit : (r_q >> 1);

	// ---- CORDIC step ----
	logic signed [39:0] xs, ys;
	logic signed [33:0] at;
	logic               ccw;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign at  = $signed({2'b00, ATAN_TAB[i_q]});
	assign ccw = vec_q ? y_q[39] : !z_q[33];

	// ---- heading update and rotation seed ----
	logic [31:0] turn, h_rev, h_new, h_rot;
	logic        wrap;

	assign turn  = deg_q ? 32'd0 : z_q[31:0];
	assign h_rev = head_q + HALF_TURN;
	assign h_new = odd_q ? h_rev - turn : h_rev + turn;
	assign wrap  = ((h_new + QUARTER_TURN) >= HALF_TURN);
	assign h_rot = wrap ? h_new - HALF_TURN : h_new;

	// ---- final point ----
	logic signed [36:0] offx_s, offy_s, neg_len, sumx, sumy;
	logic [32:0]        satx, saty, satl;

	assign offx_s  = x_q[39] ? -$signed({1'b0, offx_q}) : $signed({1'b0, offx_q});
	assign offy_s  = y_q[39] ? -$signed({1'b0, offy_q}) : $signed({1'b0, offy_q});
	assign sumx    = 37'(last_x_q) + offx_s;
	assign sumy    = 37'(last_y_q) + offy_s;
	assign neg_len = -$signed({4'd0, len_q});
	assign satx    = sat37(sumx);
	assign saty    = sat37(sumy);
	assign satl    = sat37(neg_len);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		kind_nx = MK_LEN;
		case (state_q)
			CS_IDLE: begin
				if (start)
					state_d = (job.phase == PH_ORIGIN) ? CS_FIN : CS_LNORM;
			end
			CS_LNORM: begin
				kind_nx = MK_LEN;
				if (!lbig)
					state_d = CS_MUL;
			end
			CS_MUL: begin
				if (mk_done) begin
					case (kind_q)
						MK_LEN, MK_CSQ: state_d = CS_SQRT;
						MK_CROSS:       state_d = CS_MUL;
						default:        state_d = CS_FIN;
					endcase
				end
			end
			CS_SQRT: begin
				if (sqrt_done) begin
					if (kind_q == MK_CSQ)
						state_d = CS_VINIT;
					else if (ph_q == PH_AXIS)
						state_d = CS_FIN;
					else if (deg_q)
						state_d = CS_HEAD;
					else
						state_d = CS_ANORM;
				end
			end
			CS_ANORM: begin
				kind_nx = MK_CROSS;
				if (!abig && !bbig)
					state_d = CS_MUL;
			end
			CS_VINIT: state_d = CS_CORDIC;
			CS_CORDIC: begin
				kind_nx = MK_SCALE;
				if (cordic_done)
					state_d = vec_q ? CS_HEAD : CS_MUL;
			end
			CS_HEAD: state_d = CS_CORDIC;
			CS_FIN:  state_d = CS_DONE;
			CS_DONE: begin
				if (take)
					state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					ph_q     <= job.phase;
					odd_q    <= job.odd;
					head_q   <= job.heading;
					last_x_q <= job.last_x;
					last_y_q <= job.last_y;
					am_q[0]  <= mag33(job.ax);
					am_q[1]  <= mag33(job.ay);
					am_q[2]  <= mag33(job.az);
					bm_q[0]  <= mag33(job.bx);
					bm_q[1]  <= mag33(job.by);
					bm_q[2]  <= mag33(job.bz);
					asg_q[0] <= job.ax[32];
					asg_q[1] <= job.ay[32];
					asg_q[2] <= job.az[32];
					bsg_q[0] <= job.bx[32];
					bsg_q[1] <= job.by[32];
					bsg_q[2] <= job.bz[32];
					ls_q     <= 1'b0;
					deg_q    <= (job.phase == PH_TURN) &&
					            (((job.ax == '0) && (job.ay == '0) && (job.az == '0)) ||
					             ((job.bx == '0) && (job.by == '0) && (job.bz == '0)));
				end
			end
			CS_LNORM: begin
				if (lbig) begin
					for (int k = 0; k < 3; k++)
						bm_q[k] <= bm_q[k] >> 1;
					ls_q <= 1'b1;
				end
			end
			CS_MUL: begin
				if (!mk_done)
					prod_q <= op_a * op_b;
				// cross products chain straight into their squares
				if (mk_done && (kind_q == MK_CROSS)) begin
					kind_q   <= MK_CSQ;
					mk_cnt_q <= '0;
				end else
					mk_cnt_q <= mk_cnt_q + 4'd1;
				if (mk_cnt_q != 4'd0) begin
					case (kind_q)
						MK_LEN, MK_CSQ: begin
							if (jp == 4'd0)
								acc_q <= prod_q;
							else if (jp == 4'd2) begin
								n_q <= sum_w[63:0];
								r_q <= '0;
								t_q <= '0;
							end else
								acc_q <= sum_w;
						end
						MK_CROSS: begin
							case (jp)
								4'd1:    cx_q  <= dif_w[31:0];
								4'd3:    cy_q  <= dif_w[31:0];
								4'd5:    cz_q  <= dif_w[31:0];
								4'd7:    acc_q <= sum_w;
								4'd8:    dot_q <= sum_w[33:0];
								default: acc_q <= prod_q;
							endcase
						end
						default: begin
							case (jp)
								4'd1:    offx_q <= 36'(sum_w >>> 10);
								4'd3:    offy_q <= 36'(sum_w >>> 10);
								default: acc_q  <= prod_q >>> 20;
							endcase
						end
					endcase
				end
			end
			CS_SQRT: begin
				n_q <= n_nx;
				r_q <= r_nx;
				t_q <= t_q + 5'd1;
				if (sqrt_done && (kind_q == MK_LEN))
					len_q <= {1'b0, r_nx[31:0]} << ls_q;
			end
			CS_ANORM: begin
				for (int k = 0; k < 3; k++) begin
					if (abig)
						am_q[k] <= am_q[k] >> 1;
					if (bbig)
						bm_q[k] <= bm_q[k] >> 1;
				end
			end
			CS_VINIT: begin
				// negative dot: pre-rotate by a quarter turn
				if (dot_q[33]) begin
					x_q <= $signed({8'd0, r_q[31:0]});
					y_q <= -40'(dot_q);
					z_q <= $signed({2'b00, QUARTER_TURN});
				end else begin
					x_q <= 40'(dot_q);
					y_q <= $signed({8'd0, r_q[31:0]});
					z_q <= '0;
				end
				i_q   <= '0;
				vec_q <= 1'b1;
			end
			CS_CORDIC: begin
				if (ccw) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				i_q <= i_q + 5'd1;
			end
			CS_HEAD: begin
				head_q <= h_new;
				x_q    <= wrap ? -KINV_Q30 : KINV_Q30;
				y_q    <= '0;
				z_q    <= {{2{h_rot[31]}}, h_rot};
				i_q    <= '0;
				vec_q  <= 1'b0;
			end
			CS_FIN: begin
				case (ph_q)
					PH_ORIGIN: begin
						res_q.fx      <= '0;
						res_q.fy      <= '0;
						res_q.sat     <= 1'b0;
						res_q.heading <= '0;
					end
					PH_AXIS: begin
						res_q.fx      <= satl[31:0];
						res_q.fy      <= '0;
						res_q.sat     <= satl[32];
						res_q.heading <= HALF_TURN;
					end
					default: begin
						res_q.fx      <= satx[31:0];
						res_q.fy      <= saty[31:0];
						res_q.sat     <= satx[32] | saty[32];
						res_q.heading <= head_q;
					end
				endcase
				res_q.deg <= deg_q;
			end
			default: ;
		endcase
		if ((state_d == CS_MUL) && (state_q != CS_MUL)) begin
			kind_q   <= kind_nx;
			mk_cnt_q <= '0;
		end
	end

	assign busy      = (state_q != CS_IDLE);
	assign res_valid = (state_q == CS_DONE);
	assign res       = res_q;

endmodule

FILE: hw/rtl/triangle_strip_unfolder.sv
// One vertex at a time: s_axis_tready is low from the transfer until its result is latched
// and stays low during any output stall. Work per vertex uses the shared multiplier, the
// 32-step square root (twice for a later vertex with a non-degenerate turn), the 24-step
// CORDIC (vectoring, then rotation) and the normalising shifts; arst_n low clears all history.
`timescale 1ns / 1ps
module triangle_strip_unfolder import tsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // vx, vy, vz
	input  logic [0:0]       s_axis_tuser,  // start_strip
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // flat_x, flat_y
	output logic [2:0]       m_axis_tuser   // odd_edge, degenerate, saturated
);

	// vertex history: [0] is the previous vertex, [1] the one before
	logic signed [COORD_W-1:0] px_q [2];
	logic signed [COORD_W-1:0] py_q [2];
	logic signed [COORD_W-1:0] pz_q [2];
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic [31:0]               heading_q;
	phase_t                    phase_q, ph_eff, ph_next;
	logic                      parity_q, odd_eff;

	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;
	logic [2:0]         m_user_q;

	logic signed [COORD_W-1:0] vx, vy, vz;
	logic  s_xfer, take, core_busy, core_done;
	job_t  job;
	res_t  res;

	assign vx = s_axis_tdata[COORD_W-1:0];
	assign vy = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign vz = s_axis_tdata[3*COORD_W-1:2*COORD_W];

	assign s_axis_tready = !core_busy;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	// start_strip or the first vertex after reset begins a strip
	assign ph_eff = s_axis_tuser[0] ? PH_ORIGIN : phase_q;

	always_comb begin
		case (ph_eff)
			PH_ORIGIN: begin ph_next = PH_AXIS; odd_eff = 1'b0;      end
			PH_AXIS:   begin ph_next = PH_TURN; odd_eff = 1'b1;      end
			default:   begin ph_next = PH_TURN; odd_eff = !parity_q; end
		endcase
	end

	always_comb begin
		job.phase   = ph_eff;
		job.odd     = odd_eff;
		job.heading = heading_q;
		job.last_x  = last_x_q;
		job.last_y  = last_y_q;
		job.ax      = 33'(px_q[1]) - 33'(px_q[0]);
		job.ay      = 33'(py_q[1]) - 33'(py_q[0]);
		job.az      = 33'(pz_q[1]) - 33'(pz_q[0]);
		job.bx      = 33'(vx) - 33'(px_q[0]);
		job.by      = 33'(vy) - 33'(py_q[0]);
		job.bz      = 33'(vz) - 33'(pz_q[0]);
	end

	tsu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_xfer),
		.take      (take),
		.job       (job),
		.busy      (core_busy),
		.res_valid (core_done),
		.res       (res)
	);

	// result moves to the output register when that slot is free or draining
	assign take = core_done && (!m_valid_q || m_axis_tready);

	// history, phase and parity update on the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q[0]  <= '0;
			px_q[1]  <= '0;
			py_q[0]  <= '0;
			py_q[1]  <= '0;
			pz_q[0]  <= '0;
			pz_q[1]  <= '0;
			phase_q  <= PH_ORIGIN;
			parity_q <= 1'b0;
		end else if (s_xfer) begin
			px_q[1]  <= px_q[0];
			py_q[1]  <= py_q[0];
			pz_q[1]  <= pz_q[0];
			px_q[0]  <= vx;
			py_q[0]  <= vy;
			pz_q[0]  <= vz;
			phase_q  <= ph_next;
			parity_q <= odd_eff;
		end
	end

	// last point and heading update when the result is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q  <= '0;
			last_y_q  <= '0;
			heading_q <= '0;
		end else if (take) begin
			last_x_q  <= res.fx;
			last_y_q  <= res.fy;
			heading_q <= res.heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (take)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_data_q <= {res.fy, res.fx};
			m_user_q <= {res.sat, res.deg, parity_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

FILE: hw/rtl/tsu_checker.sv
// Port-level checks of the triangle strip unfolder, bound to the top level.
`timescale 1ns / 1ps
`include "triangle_strip_unfolder_assert.svh"
module tsu_checker import tsu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic [2:0]       m_axis_tuser
);

	// stalled result holds
	`TSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// one vertex at a time: the core is busy right after a transfer
	`TSU_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// no result can appear the cycle after a vertex transfer
	`TSU_ASSERT_IMPL(a_no_fast_result, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready))

endmodule

bind triangle_strip_unfolder tsu_checker u_tsu_checker (.*);
